[hw/rtl/ftrc_pkg.sv]
package ftrc_pkg;

    localparam logic CMD_CHECK  = 1'b0;
    localparam logic CMD_APPEND = 1'b1;

    localparam logic [1:0] SVC_TCP  = 2'd0;
    localparam logic [1:0] SVC_UDP  = 2'd1;
    localparam logic [1:0] SVC_ICMP = 2'd2;
    localparam logic [1:0] SVC_ANY  = 2'd3;

    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 16;
    localparam int HELD_W     = 7;

    typedef struct packed {
        logic        direction;
        logic [1:0]  service;
        logic        action;
        logic        source_address_wild;
        logic        dest_address_wild;
        logic        source_port_wild;
        logic        dest_port_wild;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port_num;
        logic [15:0] dest_port_num;
    } rule_t;

    typedef struct packed {
        logic  valid;
        logic  command;
        logic  verdict;
        logic  status;
        rule_t fields;
    } item_t;

endpackage

[hw/rtl/ftrc_cell.sv]
module ftrc_cell
    import ftrc_pkg::*;
#(
    parameter int CW    = 7,
    parameter int INDEX = 0
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  item_t         item_in,
    input  logic [CW-1:0] count_in,
    output item_t         item_out,
    output logic [CW-1:0] count_out
);

    localparam logic [CW-1:0] SLOT      = CW'(INDEX);
    localparam logic [CW-1:0] SLOT_NEXT = CW'(INDEX + 1);

    item_t         item_reg;
    item_t         item_next;
    logic [CW-1:0] count_reg;
    rule_t         rule_reg;
    logic          store;
    logic          hit;
    logic          addr_ok;
    logic          port_ok;
    logic          svc_ok;

    always_comb
    begin
        addr_ok = (rule_reg.source_address_wild
                   || rule_reg.source_address == item_in.fields.source_address)
               && (rule_reg.dest_address_wild
                   || rule_reg.dest_address == item_in.fields.dest_address);
        port_ok = (item_in.fields.service == SVC_ICMP)
               || ((rule_reg.source_port_wild
                    || rule_reg.source_port_num == item_in.fields.source_port_num)
                   && (rule_reg.dest_port_wild
                    || rule_reg.dest_port_num == item_in.fields.dest_port_num));
        svc_ok  = (item_in.fields.service != SVC_ANY)
               && (rule_reg.service == item_in.fields.service || rule_reg.service == SVC_ANY);
        hit     = item_in.valid && (item_in.command == CMD_CHECK) && (SLOT < count_in)
               && (rule_reg.direction == item_in.fields.direction)
               && svc_ok && addr_ok && port_ok;
        store   = item_in.valid && (item_in.command == CMD_APPEND) && !item_in.status
               && (count_in == SLOT_NEXT);

        item_next         = item_in;
        item_next.verdict = hit ? rule_reg.action : item_in.verdict;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
        end
        else if (en)
        begin
            item_reg <= item_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            count_reg <= count_in;
        end
        if (en && store)
        begin
            rule_reg <= item_in.fields;
        end
    end

    assign item_out  = item_reg;
    assign count_out = count_reg;

endmodule

[hw/rtl/five_tuple_rule_classifier.sv]
// Firewall access-list classifier built as a chain of MAX_RULES cells, one stored rule per
// cell. An append item takes the next free slot, or comes back with status 1 when all
// MAX_RULES slots hold rules; a check item walks the chain and leaves with the action of the
// last matching rule of its direction, or the default (block inbound, allow outbound).
// Every item passes through the register of each cell in turn from acceptance to its result,
// and the chain takes one new item every cycle while the output does not stall; the whole
// chain stalls while a result waits on the output. Items leave in the order they came, and a
// check sees every append that was accepted before it. No clearing pass is needed after reset.
module five_tuple_rule_classifier
    import ftrc_pkg::*;
#(
    parameter int MAX_RULES = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // Item fields from bit 0: direction, service, source_address, dest_address,
    // source_port_num, dest_port_num, source_address_wild, dest_address_wild,
    // source_port_wild, dest_port_wild, action.
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // command.
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // Item fields from bit 0: allowed, status, rules_held, then zero padding.
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int CW = $clog2(MAX_RULES + 1);
    localparam logic [CW-1:0] LIMIT = CW'(MAX_RULES);

    logic          en;
    logic          accept;
    logic          full;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    item_t         head;
    item_t         stage   [MAX_RULES];
    logic [CW-1:0] cnt_stage [MAX_RULES];

    assign en            = !stage[MAX_RULES-1].valid || m_axis_tready;
    assign s_axis_tready = en;
    assign accept        = s_axis_tvalid && en;
    assign full          = (count_reg == LIMIT);

    always_comb
    begin
        count_next = count_reg;
        if (accept && s_axis_tuser == CMD_APPEND && !full)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        head.valid                      = s_axis_tvalid;
        head.command                    = s_axis_tuser;
        head.status                     = (s_axis_tuser == CMD_APPEND) && full;
        head.fields.direction           = s_axis_tdata[0];
        head.fields.service             = s_axis_tdata[2:1];
        head.fields.source_address      = s_axis_tdata[34:3];
        head.fields.dest_address        = s_axis_tdata[66:35];
        head.fields.source_port_num     = s_axis_tdata[82:67];
        head.fields.dest_port_num       = s_axis_tdata[98:83];
        head.fields.source_address_wild = s_axis_tdata[99];
        head.fields.dest_address_wild   = s_axis_tdata[100];
        head.fields.source_port_wild    = s_axis_tdata[101];
        head.fields.dest_port_wild      = s_axis_tdata[102];
        head.fields.action              = s_axis_tdata[103];
        head.verdict                    = (s_axis_tuser == CMD_CHECK) && s_axis_tdata[0];
    end

    for (genvar i = 0; i < MAX_RULES; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            ftrc_cell #(.CW(CW), .INDEX(i)) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .item_in   (head),
                .count_in  (count_next),
                .item_out  (stage[i]),
                .count_out (cnt_stage[i])
            );
        end
        else
        begin : g_rest
            ftrc_cell #(.CW(CW), .INDEX(i)) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .item_in   (stage[i-1]),
                .count_in  (cnt_stage[i-1]),
                .item_out  (stage[i]),
                .count_out (cnt_stage[i])
            );
        end
    end

    assign m_axis_tvalid = stage[MAX_RULES-1].valid;
    assign m_axis_tdata  = {7'b0, HELD_W'(cnt_stage[MAX_RULES-1]),
                            stage[MAX_RULES-1].status, stage[MAX_RULES-1].verdict};

endmodule

[hw/rtl/ftrc_checker.sv]
module ftrc_checker
    import ftrc_pkg::*;
#(
    parameter int MAX_RULES = 64
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam logic [HELD_W-1:0] FULL_HELD = HELD_W'(MAX_RULES);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Result item changed while stalled.");

    a_refused_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> !m_axis_tdata[0])
        else $error("Refused append reports an allow verdict.");

    a_refused_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[8:2] == FULL_HELD)
        else $error("Append refused while the table was not full.");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("Item accepted while the chain is stalled.");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:9] == 7'b0)
        else $error("Result padding bits are not zero.");

endmodule

bind five_tuple_rule_classifier ftrc_checker #(.MAX_RULES(MAX_RULES)) u_ftrc_checker (.*);

[verif/tb_top.sv]
module tb_top
    import ftrc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 11;
    localparam int RULE_SLOTS   = 64;
    localparam int RANDOM_ITEMS = 500;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int IDLE_PCT     = 23;

    typedef struct packed {
        logic              allowed;
        logic              status;
        logic [HELD_W-1:0] held;
    } outcome_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = CMD_CHECK;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    rule_t    rule_store [RULE_SLOTS];
    int       rules_stored = 0;
    outcome_t pending_outcomes [$];
    bit       steady = 1'b0;
    int       error_count = 0;
    int       cycle_count = 0;
    int       n_checks = 0;
    int       n_allowed = 0;
    int       n_appends = 0;
    int       n_refused = 0;
    logic [31:0] addr_pool [4];
    logic [15:0] port_pool [4];

    five_tuple_rule_classifier #(
        .MAX_RULES(RULE_SLOTS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(negedge clk)
    begin
        m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic logic [IN_DATA_W-1:0] pack_fields(input rule_t it);
        return {it.action, it.dest_port_wild, it.source_port_wild, it.dest_address_wild,
                it.source_address_wild, it.dest_port_num, it.source_port_num,
                it.dest_address, it.source_address, it.service, it.direction};
    endfunction

    function automatic bit rule_hits(input rule_t r, input rule_t pkt);
        if (r.direction != pkt.direction)
            return 1'b0;
        if (r.service != pkt.service && r.service != SVC_ANY)
            return 1'b0;
        if (!r.source_address_wild && r.source_address != pkt.source_address)
            return 1'b0;
        if (!r.dest_address_wild && r.dest_address != pkt.dest_address)
            return 1'b0;
        if (pkt.service == SVC_ICMP)
            return 1'b1;
        if (!r.source_port_wild && r.source_port_num != pkt.source_port_num)
            return 1'b0;
        if (!r.dest_port_wild && r.dest_port_num != pkt.dest_port_num)
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic outcome_t classify_item(input logic cmd, input rule_t it);
        outcome_t res;
        res = '0;
        if (cmd == CMD_APPEND)
        begin
            n_appends++;
            if (rules_stored >= RULE_SLOTS)
            begin
                res.status = 1'b1;
                n_refused++;
            end
            else
            begin
                rule_store[rules_stored] = it;
                rules_stored++;
            end
        end
        else
        begin
            n_checks++;
            res.allowed = it.direction;
            if (it.service != SVC_ANY)
            begin
                for (int i = 0; i < rules_stored; i++)
                begin
                    if (rule_hits(rule_store[i], it))
                        res.allowed = rule_store[i].action;
                end
            end
            if (res.allowed)
                n_allowed++;
        end
        res.held = rules_stored[HELD_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic send_item(input logic cmd, input rule_t it);
        @(negedge clk);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_fields(it);
        s_axis_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_outcomes.push_back(classify_item(cmd, it));
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                report_mismatch("unexpected item", 1, 0);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (m_axis_tdata[0] !== want.allowed)
                    report_mismatch("allowed", int'(m_axis_tdata[0]), int'(want.allowed));
                if (m_axis_tdata[1] !== want.status)
                    report_mismatch("status", int'(m_axis_tdata[1]), int'(want.status));
                if (m_axis_tdata[HELD_W+1:2] !== want.held)
                    report_mismatch("rules_held", int'(m_axis_tdata[HELD_W+1:2]),
                                    int'(want.held));
            end
        end
    end

    function automatic logic [31:0] pick_address();
        if ($urandom_range(3) == 0)
            return $urandom;
        return addr_pool[$urandom_range(3)];
    endfunction

    function automatic logic [15:0] pick_port();
        if ($urandom_range(3) == 0)
            return 16'($urandom_range(16'hFFFF));
        return port_pool[$urandom_range(3)];
    endfunction

    function automatic rule_t random_rule();
        rule_t r;
        r.direction           = 1'($urandom_range(1));
        r.service             = 2'($urandom_range(3));
        r.action              = 1'($urandom_range(1));
        r.source_address_wild = ($urandom_range(99) < 30);
        r.dest_address_wild   = ($urandom_range(99) < 30);
        r.source_port_wild    = ($urandom_range(99) < 30);
        r.dest_port_wild      = ($urandom_range(99) < 30);
        r.source_address      = pick_address();
        r.dest_address        = pick_address();
        r.source_port_num     = pick_port();
        r.dest_port_num       = pick_port();
        return r;
    endfunction

    // A packet built from a stored rule reaches the matching logic; a few get one field
    // disturbed so that near misses are exercised as well.
    function automatic rule_t packet_near_rule();
        rule_t p;
        rule_t noise;
        noise = random_rule();
        if (rules_stored == 0 || $urandom_range(99) < 20)
            return noise;
        p = rule_store[$urandom_range(rules_stored - 1)];
        if (p.service == SVC_ANY)
            p.service = ($urandom_range(9) == 0) ? SVC_ANY : 2'($urandom_range(2));
        p.action              = noise.action;
        p.source_address_wild = noise.source_address_wild;
        p.dest_address_wild   = noise.dest_address_wild;
        p.source_port_wild    = noise.source_port_wild;
        p.dest_port_wild      = noise.dest_port_wild;
        if ($urandom_range(99) < 30)
        begin
            case ($urandom_range(4))
                0: p.direction = ~p.direction;
                1: p.source_address = noise.source_address;
                2: p.dest_address = noise.dest_address;
                3: p.source_port_num = noise.source_port_num;
                default: p.dest_port_num = noise.dest_port_num;
            endcase
        end
        return p;
    endfunction

    task automatic test_empty_table();
        rule_t p;
        for (int d = 0; d < 2; d++)
        begin
            for (int s = 0; s < 4; s++)
            begin
                p = (s[0] ^ d[0]) ? '1 : '0;
                p.direction = d[0];
                p.service   = s[1:0];
                send_item(CMD_CHECK, p);
            end
        end
    endtask

    task automatic test_rule_matching();
        rule_t r;
        rule_t p;

        r = '0;
        r.direction      = 1'b0;
        r.service        = SVC_TCP;
        r.action         = 1'b1;
        r.source_address = 32'hFFFF_FFFF;
        r.source_port_num = 16'hFFFF;
        send_item(CMD_APPEND, r);
        p = r;
        send_item(CMD_CHECK, p);
        p.dest_port_num = 16'h0001;
        send_item(CMD_CHECK, p);

        r = '0;
        r.direction           = 1'b1;
        r.service             = SVC_ICMP;
        r.source_address_wild = 1'b1;
        r.dest_address        = 32'h0A00_0001;
        r.source_port_num     = 16'd1234;
        r.dest_port_num       = 16'd5678;
        send_item(CMD_APPEND, r);
        p = r;
        p.source_address_wild = 1'b0;
        p.source_address      = 32'hC0A8_0101;
        p.source_port_num     = 16'd7;
        p.dest_port_num       = 16'hFFFF;
        send_item(CMD_CHECK, p);
        p.service = SVC_UDP;
        send_item(CMD_CHECK, p);

        r = '1;
        r.direction = 1'b0;
        r.service   = SVC_ANY;
        send_item(CMD_APPEND, r);
        p = '0;
        p.direction      = 1'b0;
        p.service        = SVC_UDP;
        p.source_address = 32'h1234_5678;
        send_item(CMD_CHECK, p);
        p.service = SVC_ANY;
        send_item(CMD_CHECK, p);

        r = '0;
        r.direction           = 1'b0;
        r.service             = SVC_UDP;
        r.action              = 1'b0;
        r.source_address_wild = 1'b1;
        r.dest_address_wild   = 1'b1;
        r.source_port_wild    = 1'b1;
        r.dest_port_num       = 16'd53;
        send_item(CMD_APPEND, r);
        p = '0;
        p.direction     = 1'b0;
        p.service       = SVC_UDP;
        p.dest_port_num = 16'd53;
        send_item(CMD_CHECK, p);
        p.dest_port_num = 16'd54;
        send_item(CMD_CHECK, p);

        // The wild and action fields of a check are don't-care for the verdict.
        p.dest_port_num       = 16'd53;
        p.action              = 1'b1;
        p.source_address_wild = 1'b1;
        p.dest_address_wild   = 1'b1;
        p.source_port_wild    = 1'b1;
        p.dest_port_wild      = 1'b1;
        send_item(CMD_CHECK, p);
    endtask

    task automatic test_random_traffic();
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 2)
                wait_for_drain();
            steady = (i >= 300 && i < 380);
            if ($urandom_range(99) < 15)
                send_item(CMD_APPEND, random_rule());
            else
                send_item(CMD_CHECK, packet_near_rule());
        end
        steady = 1'b0;
    endtask

    task automatic test_table_full();
        while (rules_stored < RULE_SLOTS)
            send_item(CMD_APPEND, random_rule());
        repeat (2)
        begin
            send_item(CMD_APPEND, random_rule());
            send_item(CMD_CHECK, packet_near_rule());
        end
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("five_tuple_rule_classifier regression: fail");
        $finish;
    end

    initial
    begin
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFFF;
        addr_pool[2] = $urandom;
        addr_pool[3] = $urandom;
        port_pool[0] = 16'h0000;
        port_pool[1] = 16'hFFFF;
        port_pool[2] = 16'd80;
        port_pool[3] = 16'($urandom_range(16'hFFFF));
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_rule_matching();
        test_random_traffic();
        test_table_full();

        wait_for_drain();
        repeat (2 * RULE_SLOTS) @(posedge clk);
        $display("Covered %0d checks (%0d allowed, %0d blocked) and %0d appends,",
                 n_checks, n_allowed, n_checks - n_allowed, n_appends);
        $display("%0d of them refused by a full table of %0d rules, %0d mismatches.",
                 n_refused, RULE_SLOTS, error_count);
        if (error_count == 0)
            $display("five_tuple_rule_classifier regression: pass");
        else
            $display("five_tuple_rule_classifier regression: fail");
        $finish;
    end

endmodule
